>>> src/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; every macro samples on clk and is disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge of clk outside reset
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must hold in the cycle after a trigger
`define CHK_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

>>> src/tga_rle_pkg.sv
// shared types, constants and helpers for the targa rle pixel decoder
// no dependencies; imported by every module of the block
package tga_rle_pkg;

    localparam int MAX_SIDE  = 32767;
    localparam int SIDE_W    = 15;
    localparam int INDEX_W   = 30;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = SIDE_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_RLE_ENABLE   = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } cfg_reg_t;

    // pixel format codes
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_BGR  = 2'd1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // settled configuration as seen by the decode core
    typedef struct packed {
        logic [1:0]         pixel_format;
        logic               rle_enable;
        logic [INDEX_W-1:0] total;
        logic               total_stale;
    } cfg_t;

    // one decoded result
    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [INDEX_W-1:0] first_index;
        logic [COUNT_W-1:0] repeat_count;
        logic               image_done;
    } result_t;

    // zero side means one; the register cannot exceed the maximum side
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIDE_W'(1);
        else if (32'(v) > MAX_SIDE)
            r = SIDE_W'(MAX_SIDE);
        return r;
    endfunction

    // bytes per pixel: gray 1, bgr 3, anything else 4
    function automatic logic [2:0] bytes_per_pixel(input logic [1:0] fmt);
        logic [2:0] r;
        r = 3'd4;
        if (fmt == FMT_GRAY)
            r = 3'd1;
        else if (fmt == FMT_BGR)
            r = 3'd3;
        return r;
    endfunction

endpackage

>>> src/tga_rle_cfg_regs.sv
// configuration registers and the registered pixel total of the image
// depends on tga_rle_pkg
module tga_rle_cfg_regs
    import tga_rle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [1:0]         pixel_format_reg;
    logic               rle_enable_reg;
    logic [SIDE_W-1:0]  image_width_reg;
    logic [SIDE_W-1:0]  image_height_reg;
    logic [INDEX_W-1:0] total_reg;
    logic [INDEX_W-1:0] total_next;
    logic               stale_reg;
    logic               stale_next;

    // width times height on clamped sides, zero extended to the product width
    assign total_next = {{(INDEX_W-SIDE_W){1'b0}}, clamp_side(image_width_reg)}
                      * {{(INDEX_W-SIDE_W){1'b0}}, clamp_side(image_height_reg)};

    // the registered total is stale in the cycle after a size write
    assign stale_next = cfg_we && ((cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH)
                                || (cfg_reg_t'(cfg_index) == REG_IMAGE_HEIGHT));

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FMT_GRAY;
            rle_enable_reg   <= 1'b0;
            image_width_reg  <= SIDE_W'(1);
            image_height_reg <= SIDE_W'(1);
            total_reg        <= INDEX_W'(1);
            stale_reg        <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            stale_reg <= stale_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[1:0];
                    REG_RLE_ENABLE:   rle_enable_reg   <= cfg_data[0];
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[SIDE_W-1:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[SIDE_W-1:0];
                    default:          pixel_format_reg <= pixel_format_reg;
                endcase
            end
        end
    end

    assign cfg.pixel_format = pixel_format_reg;
    assign cfg.rle_enable   = rle_enable_reg;
    assign cfg.total        = total_reg;
    assign cfg.total_stale  = stale_reg;

endmodule

>>> src/tga_rle_in_stage.sv
// input register: holds one accepted byte until the core takes it
// depends on tga_rle_pkg
module tga_rle_in_stage
    import tga_rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    // free when empty or when the core takes the held beat this cycle
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= data_byte;
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

>>> src/tga_rle_core.sv
// packet and pixel decode: state registers, decode logic and result register
// depends on tga_rle_pkg
module tga_rle_core
    import tga_rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    output logic       take,
    output logic       out_valid,
    input  logic       out_stall,
    output result_t    result
);

    logic               in_packet_reg, in_packet_next;
    logic               is_run_reg, is_run_next;
    logic [7:0]         left_reg, left_next;
    logic [1:0]         bip_reg, bip_next;
    logic [23:0]        color_reg, color_next;
    logic [INDEX_W-1:0] counter_reg, counter_next;
    logic               finished_reg, finished_next;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;

    logic               out_free;
    logic               emit;
    logic [2:0]         bpp;
    logic [23:0]        color_base;
    logic [7:0]         left_dec;
    logic [COUNT_W-1:0] count_raw;
    logic [INDEX_W-1:0] remaining;
    logic               last;

    // take a beat when the result register can be refilled and the total is current
    assign out_free = !out_valid_reg || !out_stall;
    assign take     = item_valid && out_free && !cfg.total_stale;
    assign bpp      = bytes_per_pixel(cfg.pixel_format);
    assign remaining = cfg.total - counter_reg;

    // decode of one byte
    always_comb
    begin
        in_packet_next = in_packet_reg;
        is_run_next    = is_run_reg;
        left_next      = left_reg;
        bip_next       = bip_reg;
        color_next     = color_reg;
        counter_next   = counter_reg;
        finished_next  = finished_reg;
        emit           = 1'b0;
        result_next    = result_reg;
        color_base     = (bip_reg == 2'd0) ? 24'd0 : color_reg;
        left_dec       = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
        count_raw      = COUNT_W'(1);
        last           = 1'b0;

        if (finished_reg || (counter_reg >= cfg.total))
        begin
            // image complete: swallow trailing bytes
            finished_next = 1'b1;
        end
        else if (cfg.rle_enable && !in_packet_reg)
        begin
            // packet header
            is_run_next    = item_byte[7];
            left_next      = {1'b0, item_byte[6:0]} + 8'd1;
            in_packet_next = 1'b1;
            bip_next       = 2'd0;
            color_next     = 24'd0;
        end
        else if (({1'b0, bip_reg} + 3'd1) < bpp)
        begin
            // gather an early byte of a multi byte pixel
            case (bip_reg)
                2'd0:    color_next = color_base | {16'd0, item_byte};
                2'd1:    color_next = color_base | {8'd0, item_byte, 8'd0};
                2'd2:    color_next = color_base | {item_byte, 16'd0};
                default: color_next = color_base;
            endcase
            bip_next = bip_reg + 2'd1;
        end
        else
        begin
            // last byte of a pixel: form the color and the count
            emit = 1'b1;
            if (cfg.pixel_format == FMT_GRAY)
            begin
                result_next.red   = item_byte;
                result_next.green = item_byte;
                result_next.blue  = item_byte;
                result_next.alpha = ALPHA_OPAQUE;
            end
            else if (cfg.pixel_format == FMT_BGR)
            begin
                result_next.blue  = color_reg[7:0];
                result_next.green = color_reg[15:8];
                result_next.red   = item_byte;
                result_next.alpha = ALPHA_OPAQUE;
            end
            else
            begin
                result_next.blue  = color_reg[7:0];
                result_next.green = color_reg[15:8];
                result_next.red   = color_reg[23:16];
                result_next.alpha = item_byte;
            end
            bip_next   = 2'd0;
            color_next = 24'd0;

            if (cfg.rle_enable)
            begin
                if (is_run_reg)
                begin
                    count_raw      = (left_reg != 8'd0) ? left_reg : COUNT_W'(1);
                    in_packet_next = 1'b0;
                    left_next      = 8'd0;
                end
                else
                begin
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                        in_packet_next = 1'b0;
                end
            end

            // clamp to the pixels that remain
            last = {{(INDEX_W-COUNT_W){1'b0}}, count_raw} >= remaining;
            result_next.first_index  = counter_reg;
            result_next.repeat_count = last ? remaining[COUNT_W-1:0] : count_raw;
            result_next.image_done   = last;
            counter_next  = counter_reg + {{(INDEX_W-COUNT_W){1'b0}},
                                           result_next.repeat_count};
            finished_next = last;
        end
    end

    // result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && emit)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            is_run_reg    <= 1'b0;
            left_reg      <= 8'd0;
            bip_reg       <= 2'd0;
            color_reg     <= 24'd0;
            counter_reg   <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                in_packet_reg <= in_packet_next;
                is_run_reg    <= is_run_next;
                left_reg      <= left_next;
                bip_reg       <= bip_next;
                color_reg     <= color_next;
                counter_reg   <= counter_next;
                finished_reg  <= finished_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && emit)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

>>> src/tga_rle_pixel_decoder_top.sv
// Targa pixel data decoder, top level: one byte of the pixel data area per
// beat in, one RGBA color with its first pixel index and repeat count per
// beat out. Gray, BGR and BGRA pixels, raw or run length packet coded, are
// supported; a run packet yields a single beat. A byte enters the input
// register and is decoded from there into the result register. The block
// takes one byte every cycle; the only gaps are the cycle right after a
// write to image_width or image_height, while the registered pixel total
// (one 15 by 15 bit multiply) settles, and cycles where the output is
// stalled.
// Bytes past the last pixel of the image are consumed without a result.
// depends on tga_rle_pkg, tga_rle_cfg_regs, tga_rle_in_stage, tga_rle_core
module tga_rle_pixel_decoder_top
    import tga_rle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // byte input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    // pixel output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [7:0]            alpha,
    output logic [INDEX_W-1:0]    first_index,
    output logic [COUNT_W-1:0]    repeat_count,
    output logic                  image_done
);

    cfg_t       cfg;
    logic       item_valid;
    logic [7:0] item_byte;
    logic       take;
    result_t    result;

    // configuration registers
    tga_rle_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    tga_rle_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    // decode and result register
    tga_rle_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    // result fields
    assign red          = result.red;
    assign green        = result.green;
    assign blue         = result.blue;
    assign alpha        = result.alpha;
    assign first_index  = result.first_index;
    assign repeat_count = result.repeat_count;
    assign image_done   = result.image_done;

endmodule

>>> src/tga_rle_checker.sv
// port level checks of the decoder top and the bind that attaches them
// depends on tga_rle_pkg, assert_macros.svh, tga_rle_pixel_decoder_top
`include "assert_macros.svh"

module tga_rle_checker
    import tga_rle_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [INDEX_W-1:0] first_index,
    input logic [COUNT_W-1:0] repeat_count,
    input logic               image_done
);

    // a stalled result beat stays
    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result beat dropped")

    // a stalled result keeps its index
    `CHK_NEXT(a_index_hold, out_valid && out_stall, $stable(first_index), "stalled index changed")

    // a result covers one to 128 pixels
    `CHK_ASSERT(a_count_range, out_valid |-> (repeat_count != '0) && (repeat_count <= COUNT_W'(128)), "repeat count out of range")

    // nothing follows the beat that completes the image
    `CHK_NEXT(a_done_last, out_valid && !out_stall && image_done, !out_valid, "result after image end")

endmodule

bind tga_rle_pixel_decoder_top tga_rle_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_index  (first_index),
    .repeat_count (repeat_count),
    .image_done   (image_done)
);

>>> test/testbench.sv
// testbench for tga_rle_pixel_decoder_top: directed and random pixel byte streams
// are decoded by a bench-side predictor and every output beat is checked field by field
// depends on tga_rle_pkg and the decoder rtl
`timescale 1ns / 1ps

module testbench;
    import tga_rle_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_BYTES  = 1330;
    // keeps the pixel total well above anything the random streams can reach
    localparam int PIXEL_MARGIN  = 400000;

    // format codes without a name in the package
    localparam logic [1:0] FMT_BGRA     = 2'd2;
    localparam logic [1:0] FMT_BGRA_ALT = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PIXEL_FORMAT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            data_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic [INDEX_W-1:0]    first_index;
    logic [COUNT_W-1:0]    repeat_count;
    logic                  image_done;

    // predictor copy of the registers and decode state
    logic [1:0]            cur_format = FMT_GRAY;
    logic                  cur_rle = 1'b0;
    logic [SIDE_W-1:0]     cur_width = SIDE_W'(1);
    logic [SIDE_W-1:0]     cur_height = SIDE_W'(1);
    logic                  pkt_open = 1'b0;
    logic                  pkt_run = 1'b0;
    logic [7:0]            pkt_left = '0;
    logic [1:0]            byte_pos = '0;
    logic [23:0]           color_acc = '0;
    logic [INDEX_W-1:0]    pix_count = '0;
    logic                  img_finished = 1'b0;

    result_t               pixel_q[$];
    int                    error_count = 0;
    int                    send_gap_max = 0;
    int                    stall_max = 0;
    int                    stall_left = 0;
    int                    quiet_cycles = 0;
    int                    bytes_sent = 0;

    tga_rle_pixel_decoder_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .first_index  (first_index),
        .repeat_count (repeat_count),
        .image_done   (image_done)
    );

    always #5 clk = ~clk;

    // zero side counts as one; the register cannot go past the maximum side
    function automatic int unsigned side_or_one(input logic [SIDE_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int pixel_bytes();
        return (cur_format == FMT_GRAY) ? 1 : (cur_format == FMT_BGR) ? 3 : 4;
    endfunction

    // advance the predictor by one accepted byte, queue the pixel it completes
    function automatic void decode_byte(input logic [7:0] b);
        int unsigned total;
        int unsigned count;
        int          pix_bytes;
        result_t     res;
        total = side_or_one(cur_width) * side_or_one(cur_height);
        if (img_finished || pix_count >= total) begin
            img_finished = 1'b1;
            return;
        end
        // packet header: no pixel, restarts the byte count
        if (cur_rle && !pkt_open) begin
            pkt_run   = b[7];
            pkt_left  = {1'b0, b[6:0]} + 8'd1;
            pkt_open  = 1'b1;
            byte_pos  = '0;
            color_acc = '0;
            return;
        end
        pix_bytes = pixel_bytes();
        // leading bytes of a pixel
        if (int'(byte_pos) + 1 < pix_bytes) begin
            if (byte_pos == 2'd0)
                color_acc = '0;
            color_acc = color_acc | 24'(32'(b) << (8 * int'(byte_pos)));
            byte_pos  = byte_pos + 2'd1;
            return;
        end
        // last byte completes the pixel
        if (pix_bytes == 1) begin
            res.red   = b;
            res.green = b;
            res.blue  = b;
            res.alpha = ALPHA_OPAQUE;
        end
        else begin
            res.blue  = color_acc[7:0];
            res.green = color_acc[15:8];
            res.red   = (pix_bytes == 3) ? b : color_acc[23:16];
            res.alpha = (pix_bytes == 3) ? ALPHA_OPAQUE : b;
        end
        byte_pos  = '0;
        color_acc = '0;
        count = 1;
        if (cur_rle) begin
            if (pkt_run) begin
                count    = (pkt_left != 0) ? int'(pkt_left) : 1;
                pkt_open = 1'b0;
                pkt_left = '0;
            end
            else begin
                if (pkt_left != 0)
                    pkt_left = pkt_left - 8'd1;
                if (pkt_left == 0)
                    pkt_open = 1'b0;
            end
        end
        // clamp runs to the pixels left in the image
        if (count > total - pix_count)
            count = total - pix_count;
        res.first_index  = pix_count;
        res.repeat_count = COUNT_W'(count);
        pix_count        = pix_count + INDEX_W'(count);
        img_finished     = (pix_count >= total);
        res.image_done   = img_finished;
        pixel_q.push_back(res);
    endfunction

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, input logic [31:0] idx);
        if (got !== want)
            report_error($sformatf("pixel %0d: %s is %0h, expected %0h", idx, name, got, want));
    endtask

    // output side: check each beat and draw a stall after it
    always @(posedge clk) begin : beat_check
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pixel_q.size() == 0)
                report_error($sformatf("beat with no pixel pending, first_index %0d",
                                       first_index));
            else begin
                want = pixel_q.pop_front();
                check_field("red", want.red, red, want.first_index);
                check_field("green", want.green, green, want.first_index);
                check_field("blue", want.blue, blue, want.first_index);
                check_field("alpha", want.alpha, alpha, want.first_index);
                check_field("first_index", want.first_index, first_index, want.first_index);
                check_field("repeat_count", want.repeat_count, repeat_count,
                            want.first_index);
                check_field("image_done", want.image_done, image_done, want.first_index);
            end
            stall_left = $urandom_range(stall_max, 0);
        end
        else if (stall_left > 0)
            stall_left--;
        out_stall <= (stall_left > 0);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // send one byte after a random gap and feed it to the predictor once taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        decode_byte(b);
        bytes_sent++;
    endtask

    // hold input, wait for every pending pixel, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PIXEL_FORMAT: cur_format = value[1:0];
            REG_RLE_ENABLE:   cur_rle = value[0];
            REG_IMAGE_WIDTH:  cur_width = value;
            REG_IMAGE_HEIGHT: cur_height = value;
            default: ;
        endcase
    endtask

    task automatic send_pixel();
        repeat (pixel_bytes()) send_byte(8'($urandom));
    endtask

    task automatic send_packet(input logic is_run, input logic [6:0] len_m1);
        send_byte({is_run, len_m1});
        repeat (is_run ? 1 : int'(len_m1) + 1) send_pixel();
    endtask

    // gray pixels at the byte extremes, zero width counts as one
    task automatic test_gray_raw();
        send_gap_max = 0;
        stall_max    = 0;
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_SIDE));
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();
    endtask

    // uncompressed bgr, bgra and format code three
    task automatic test_raw_formats();
        send_gap_max = 12;
        stall_max    = 12;
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGR));
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGRA));
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h00);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGRA_ALT));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();
    endtask

    // longest run, short raw packet, shortest run
    task automatic test_rle_packets();
        send_gap_max = 3;
        stall_max    = 3;
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_GRAY));
        write_reg(REG_RLE_ENABLE, CFG_DATA_W'(1));
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h11);
        send_byte(8'hEE);
        send_byte(8'h80);
        send_byte(8'h7F);
        wait_idle();
    endtask

    // rle switched off inside a raw packet keeps the packet for later
    task automatic test_rle_pause();
        send_byte(8'h02);
        send_byte(8'h5A);
        wait_idle();
        write_reg(REG_RLE_ENABLE, '0);
        send_byte(8'hA5);
        wait_idle();
        write_reg(REG_RLE_ENABLE, CFG_DATA_W'(1));
        send_byte(8'h3C);
        send_byte(8'hC3);
        wait_idle();
    endtask

    // phases of random settings, mostly whole packets or pixels with random content
    task automatic test_random_streams();
        int start;
        int target;
        int kind;
        int lo;
        int side;
        start = bytes_sent;
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_SIDE));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_SIDE));
        while (bytes_sent - start < RANDOM_BYTES) begin
            wait_idle();
            if ($urandom_range(1, 0))
                write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(3, 0)));
            if ($urandom_range(1, 0))
                write_reg(REG_RLE_ENABLE, CFG_DATA_W'($urandom_range(9, 0) < 7));
            // new image size, still far above the pixels still to come
            if ($urandom_range(5, 0) == 0) begin
                lo   = (int'(pix_count) + PIXEL_MARGIN) / MAX_SIDE + 1;
                side = $urandom_range(MAX_SIDE, lo);
                if ($urandom_range(1, 0)) begin
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(side));
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_SIDE));
                end
                else begin
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(side));
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_SIDE));
                end
            end
            send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 12;
            stall_max    = ($urandom_range(3, 0) == 0) ? 0 : 12;
            target = bytes_sent + $urandom_range(60, 10);
            kind   = $urandom_range(9, 0);
            if (kind == 0) begin
                // plain noise
                while (bytes_sent < target)
                    send_byte(8'($urandom));
            end
            else begin
                while (bytes_sent < target) begin
                    if (cur_rle)
                        send_packet(1'($urandom),
                                    ($urandom_range(9, 0) < 8) ? 7'($urandom_range(7, 0))
                                                               : 7'($urandom_range(127, 0)));
                    else
                        send_pixel();
                end
                // cut a header or pixel short
                if (kind == 1)
                    repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
            end
        end
        wait_idle();
    endtask

    // runs clamped at the last pixel, then bytes past the end are dropped
    task automatic test_image_end();
        send_gap_max = 12;
        stall_max    = 12;
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_GRAY));
        write_reg(REG_RLE_ENABLE, CFG_DATA_W'(1));
        while (pkt_open)
            send_byte(8'($urandom));
        // make sure the last run gets cut short
        if (pix_count[6:0] == 7'd0)
            send_packet(1'b0, 7'd0);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(128));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(pix_count / 128 + 2));
        while (!img_finished)
            send_packet(1'b1, 7'd127);
        repeat (6) send_byte(8'($urandom));
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
        repeat (4) send_byte(8'($urandom));
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_gray_raw();
        test_raw_formats();
        test_rle_packets();
        test_rle_pause();
        test_random_streams();
        test_image_end();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
